// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned ENTRY_W = DATA_W + PRIO_W;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    J_HOLD = 3'd0,
    J_ZERO = 3'd1,
    J_TOP  = 3'd2,
    J_INC  = 3'd3,
    J_DEC  = 3'd4
  } jop_e;

  typedef enum logic [2:0] {
    WR_NONE      = 3'd0,
    WR_MOVE_UP   = 3'd1,
    WR_NEW_ABOVE = 3'd2,
    WR_NEW_HEAD  = 3'd3,
    WR_MOVE_DOWN = 3'd4
  } wrop_e;

  typedef enum logic [1:0] {
    F_HOLD = 2'd0,
    F_INC  = 2'd1,
    F_DEC  = 2'd2
  } fillop_e;

  typedef struct packed {
    logic    take;
    jop_e    j_op;
    wrop_e   wr_op;
    fillop_e fill_op;
    logic    found_set;
    logic    found_clr;
    logic    code_load;
    status_e code;
    logic    out_load_entry;
    logic    out_load_code;
  } cmd_t;

  typedef struct packed {
    op_e  func;
    logic full;
    logic empty;
    logic move;
    logic match;
    logic at_last;
    logic j_zero;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// ===== src/spq_ram.sv =====
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/spq_ctrl.sv =====
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_STEP = 6'b000010,
    S_INS_HEAD = 6'b000100,
    S_DEL_STEP = 6'b001000,
    S_DSP      = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.take = 1'b1;
          case (sts_i.func)
            OP_INSERT: begin
              if (sts_i.full) begin
                cmd.code_load = 1'b1;
                cmd.code      = ST_FULL;
                state_d       = S_RESP;
              end else if (sts_i.empty) begin
                state_d = S_INS_HEAD;
              end else begin
                cmd.j_op = J_TOP;
                state_d  = S_INS_STEP;
              end
            end
            OP_DELETE: begin
              if (sts_i.empty) begin
                cmd.code_load = 1'b1;
                cmd.code      = ST_EMPTY;
                state_d       = S_RESP;
              end else begin
                cmd.j_op      = J_ZERO;
                cmd.found_clr = 1'b1;
                state_d       = S_DEL_STEP;
              end
            end
            OP_DISPLAY: begin
              if (sts_i.empty) begin
                cmd.code_load = 1'b1;
                cmd.code      = ST_EMPTY;
                state_d       = S_RESP;
              end else begin
                cmd.j_op = J_ZERO;
                state_d  = S_DSP;
              end
            end
            default: begin
              cmd.code_load = 1'b1;
              cmd.code      = ST_OK;
              state_d       = S_RESP;
            end
          endcase
        end
      end
      S_INS_STEP: begin
        if (sts_i.move) begin
          cmd.wr_op = WR_MOVE_UP;
          if (sts_i.j_zero) begin
            state_d = S_INS_HEAD;
          end else begin
            cmd.j_op = J_DEC;
          end
        end else begin
          cmd.wr_op     = WR_NEW_ABOVE;
          cmd.fill_op   = F_INC;
          cmd.code_load = 1'b1;
          cmd.code      = ST_OK;
          state_d       = S_RESP;
        end
      end
      S_INS_HEAD: begin
        cmd.wr_op     = WR_NEW_HEAD;
        cmd.fill_op   = F_INC;
        cmd.code_load = 1'b1;
        cmd.code      = ST_OK;
        state_d       = S_RESP;
      end
      S_DEL_STEP: begin
        if (sts_i.found) begin
          cmd.wr_op = WR_MOVE_DOWN;
        end else if (sts_i.match) begin
          cmd.found_set = 1'b1;
        end
        if (sts_i.at_last) begin
          cmd.code_load = 1'b1;
          if (sts_i.found || sts_i.match) begin
            cmd.fill_op = F_DEC;
            cmd.code    = ST_OK;
          end else begin
            cmd.code = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end else begin
          cmd.j_op = J_INC;
        end
      end
      S_DSP: begin
        if (sts_i.out_free) begin
          cmd.out_load_entry = 1'b1;
          if (sts_i.at_last) begin
            state_d = S_IDLE;
          end else begin
            cmd.j_op = J_INC;
          end
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd.out_load_code = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

`ifndef NO_ASSERTIONS
  // an accepted item always keeps the input side stalled in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting an item");
`endif

endmodule

// ===== src/spq_dp.sv =====
`timescale 1ns / 1ps

module spq_dp import spq_pkg::*; #(
  parameter int unsigned QueueDepth = DEFAULT_QUEUE_DEPTH,
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                func_i,
  input  logic signed [DATA_W-1:0]  data_value_i,
  input  logic signed [PRIO_W-1:0]  priority_value_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [1:0]                status_o,
  output logic signed [DATA_W-1:0]  entry_data_o,
  output logic signed [PRIO_W-1:0]  entry_priority_o,
  output logic [COUNT_W-1:0]        entry_count_o,
  output logic                      last_o,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o
);

  logic [IdxW-1:0]    j_q, j_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic               found_q;
  logic [DATA_W-1:0]  data_q;
  logic [PRIO_W-1:0]  prio_q;
  status_e            code_q;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [DATA_W-1:0]  out_data_q;
  logic [PRIO_W-1:0]  out_prio_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_last_q;

  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_word;
  logic [DATA_W-1:0]  rd_data;
  logic [PRIO_W-1:0]  rd_prio;
  logic [CntW-1:0]    last_idx;
  logic [CntW+COUNT_W-1:0] count_ext;
  logic               out_free;

  spq_ram #(
    .Width (ENTRY_W),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (j_d),
    .rd_data_o (rd_word)
  );

  assign rd_data   = rd_word[ENTRY_W-1:PRIO_W];
  assign rd_prio   = rd_word[PRIO_W-1:0];
  assign last_idx  = fill_q - CntW'(1);
  assign count_ext = {{COUNT_W{1'b0}}, fill_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  // status towards the controller
  always_comb begin
    sts_o.func     = op_e'(func_i);
    sts_o.full     = (fill_q == CntW'(QueueDepth));
    sts_o.empty    = (fill_q == '0);
    sts_o.j_zero   = (j_q == '0);
    // head moves only on a strictly larger priority, later entries on equal too
    sts_o.move     = (j_q == '0) ? ($signed(rd_prio) > $signed(prio_q))
                                 : ($signed(rd_prio) >= $signed(prio_q));
    sts_o.match    = (rd_data == data_q);
    sts_o.at_last  = (CntW'(j_q) == last_idx);
    sts_o.found    = found_q;
    sts_o.out_free = out_free;
  end

  always_comb begin
    case (cmd_i.j_op)
      J_HOLD:  j_d = j_q;
      J_ZERO:  j_d = '0;
      J_TOP:   j_d = IdxW'(last_idx);
      J_INC:   j_d = j_q + IdxW'(1);
      J_DEC:   j_d = j_q - IdxW'(1);
      default: j_d = j_q;
    endcase
  end

  always_comb begin
    case (cmd_i.fill_op)
      F_HOLD:  fill_d = fill_q;
      F_INC:   fill_d = fill_q + CntW'(1);
      F_DEC:   fill_d = fill_q - CntW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_q;
    wr_data = rd_word;
    case (cmd_i.wr_op)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_MOVE_UP: begin
        wr_en   = 1'b1;
        wr_addr = j_q + IdxW'(1);
      end
      WR_NEW_ABOVE: begin
        wr_en   = 1'b1;
        wr_addr = j_q + IdxW'(1);
        wr_data = {data_q, prio_q};
      end
      WR_NEW_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {data_q, prio_q};
      end
      WR_MOVE_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = j_q - IdxW'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= '0;
      fill_q      <= '0;
      found_q     <= 1'b0;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      j_q    <= j_d;
      fill_q <= fill_d;
      if (cmd_i.found_clr) begin
        found_q <= 1'b0;
      end else if (cmd_i.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd_i.code_load) begin
        code_q <= cmd_i.code;
      end
      if (cmd_i.out_load_entry || cmd_i.out_load_code) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      data_q <= data_value_i;
      prio_q <= priority_value_i;
    end
    if (cmd_i.out_load_entry) begin
      out_status_q <= ST_OK;
      out_data_q   <= rd_data;
      out_prio_q   <= rd_prio;
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_last_q   <= sts_o.at_last;
    end else if (cmd_i.out_load_code) begin
      out_status_q <= code_q;
      out_data_q   <= '0;
      out_prio_q   <= '0;
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign entry_data_o     = out_data_q;
  assign entry_priority_o = out_prio_q;
  assign entry_count_o    = out_count_q;
  assign last_o           = out_last_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(QueueDepth))
    else $error("entry count beyond queue depth");

  // shifting never writes beyond the new end of the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CntW'(wr_addr) <= fill_q))
    else $error("write outside the occupied slots");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load_entry || cmd_i.out_load_code) |-> (!out_valid_q || !out_stall_i))
    else $error("output register loaded while its item is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill_op == F_INC) |-> (fill_q != CntW'(QueueDepth)))
    else $error("insert into a full queue");
`endif

endmodule

// ===== src/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Sorted priority queue of (data, priority) entries held in ascending priority order in one
// RAM, one item at a time. Items are taken only while the unit is idle. An insert scans
// down from the tail, moving one entry up a slot per cycle until it finds its place; an
// insert into a full queue is refused. A delete scans the whole queue from the head, moving
// the entries after the match down one slot as it goes. A display streams one entry per
// cycle from the head while the output is not stalled, with last set on the final entry.
// The entry RAM has a single read and a single write port. No clearing pass is needed
// after reset.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int unsigned QueueDepth = DEFAULT_QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic signed [PRIO_W-1:0] priority_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] entry_data_o,
  output logic signed [PRIO_W-1:0] entry_priority_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic                     last_o
);

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .func_i           (func_i),
    .data_value_i     (data_value_i),
    .priority_value_i (priority_value_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .entry_data_o     (entry_data_o),
    .entry_priority_o (entry_priority_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

// ===== bench/sorted_priority_queue_unit_test.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test import spq_pkg::*; ();

  localparam int unsigned QDEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned RANDOM_ITEMS = 380;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7FFF;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } queue_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               func_i;
  logic signed [DATA_W-1:0] data_value_i;
  logic signed [PRIO_W-1:0] priority_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] entry_data_o;
  logic signed [PRIO_W-1:0] entry_priority_o;
  logic [COUNT_W-1:0]       entry_count_o;
  logic                     last_o;

  logic signed [DATA_W-1:0] shadow_data [QDEPTH];
  logic signed [PRIO_W-1:0] shadow_prio [QDEPTH];
  int unsigned              shadow_fill;
  queue_result_t            pending_results [$];

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned full_rejects;
  int unsigned displays;
  int unsigned burst_left;
  bit          hold_request;

  sorted_priority_queue_unit #(
    .QueueDepth(QDEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .data_value_i    (data_value_i),
    .priority_value_i(priority_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_data_o    (entry_data_o),
    .entry_priority_o(entry_priority_o),
    .entry_count_o   (entry_count_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void push_result(status_e s, logic signed [DATA_W-1:0] d,
                                      logic signed [PRIO_W-1:0] p, logic lst);
    queue_result_t r;
    r.status = s;
    r.data   = d;
    r.prio   = p;
    r.count  = COUNT_W'(shadow_fill);
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_queue_op(op_e op, logic signed [DATA_W-1:0] d,
                                         logic signed [PRIO_W-1:0] p);
    int unsigned pos;
    case (op)
      OP_INSERT: begin
        if (shadow_fill >= QDEPTH) begin
          full_rejects++;
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          if (shadow_fill == 0 || shadow_prio[0] > p) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shadow_fill && shadow_prio[pos] < p) pos++;
          end
          for (int unsigned i = shadow_fill; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = d;
          shadow_prio[pos] = p;
          shadow_fill++;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (shadow_fill == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < shadow_fill && shadow_data[pos] != d) pos++;
          if (pos >= shadow_fill) begin
            push_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = pos; i + 1 < shadow_fill; i++) begin
              shadow_data[i] = shadow_data[i+1];
              shadow_prio[i] = shadow_prio[i+1];
            end
            shadow_fill--;
            push_result(ST_OK, '0, '0, 1'b1);
          end
        end
      end
      OP_DISPLAY: begin
        displays++;
        if (shadow_fill == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_fill; i++)
            push_result(ST_OK, shadow_data[i], shadow_prio[i], i + 1 == shadow_fill);
        end
      end
      default: begin
        push_result(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_data();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: begin
        case ($urandom_range(0, 3))
          0: return DATA_MIN;
          1: return DATA_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return PRIO_W'(int'($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 2))
          0: return PRIO_MIN;
          1: return PRIO_MAX;
          default: return '0;
        endcase
      end
      2: return PRIO_W'($urandom_range(0, 2) * 1000);
      default: return PRIO_W'($urandom());
    endcase
  endfunction

  // drives one item, waits for it to be taken, then updates the shadow queue
  task automatic send_item(op_e op, logic signed [DATA_W-1:0] d,
                           logic signed [PRIO_W-1:0] p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i       = 1'b1;
    func_i           = op;
    data_value_i     = d;
    priority_value_i = p;
    do @(posedge clk_i); while (in_stall_o);
    apply_queue_op(op, d, p);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %0d prio %0d count %0d last %0b",
                   status_o, entry_data_o, entry_priority_o, entry_count_o, last_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== 2'(want.status) || entry_data_o !== want.data ||
            entry_priority_o !== want.prio || entry_count_o !== want.count ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp st %0d d %0d p %0d n %0d l %0b,",
                     $realtime, want.status, want.data, want.prio, want.count, want.last,
                     " got st %0d d %0d p %0d n %0d l %0b",
                     status_o, entry_data_o, entry_priority_o, entry_count_o, last_o);
        end
      end
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    mode = 0;
    mode_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 1) == 1);
          2: out_stall_i = ($urandom_range(0, 3) == 0);
          default: out_stall_i = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic test_empty_queue();
    send_item(OP_DISPLAY, '0, '0);
    send_item(OP_DELETE, 32'sd17, '0);
    send_item(OP_NONE, DATA_MAX, PRIO_MIN);
  endtask

  // covers head placement, ties at and after the head, extremes, then the full reject and a display
  task automatic test_fill_to_full();
    send_item(OP_INSERT, DATA_MAX, 16'sd0);
    send_item(OP_INSERT, DATA_MIN, PRIO_MIN);
    send_item(OP_INSERT, 32'sd0, PRIO_MIN);
    send_item(OP_INSERT, 32'sd5, PRIO_MAX);
    send_item(OP_INSERT, 32'sd6, PRIO_MAX);
    send_item(OP_INSERT, 32'sd7, 16'sd0);
    send_item(OP_INSERT, 32'sd7, 16'sd100);
    send_item(OP_INSERT, -32'sd1, -16'sd1);
    for (int k = 0; k < 8; k++)
      send_item(OP_INSERT, 32'sd100 + k, 16'(k * 1000 - 4000));
    send_item(OP_INSERT, 32'sd42, 16'sd1);
    send_item(OP_DISPLAY, '0, '0);
  endtask

  task automatic test_delete_cases();
    send_item(OP_DELETE, 32'sd12345, '0);
    send_item(OP_DELETE, 32'sd7, '0);
    send_item(OP_DELETE, DATA_MAX, '0);
    send_item(OP_DELETE, DATA_MIN, '0);
    send_item(OP_NONE, '0, '0);
    send_item(OP_DISPLAY, '0, '0);
  endtask

  // long receiver hold while the sender keeps offering items
  task automatic test_backpressure();
    burst_left = 40;
    hold_request = 1'b1;
    for (int k = 0; k < 24; k++)
      send_item((k % 6 == 5) ? OP_DISPLAY : OP_INSERT, rand_data(), rand_prio());
  endtask

  task automatic test_random_traffic(int unsigned count);
    bit          filling;
    int unsigned r;
    logic signed [DATA_W-1:0] d;
    filling = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if (filling && shadow_fill == QDEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && shadow_fill == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      d = rand_data();
      if (shadow_fill > 0 && $urandom_range(0, 2) != 0)
        d = shadow_data[$urandom_range(0, shadow_fill - 1)];
      if (filling) begin
        if (r < 70) send_item(OP_INSERT, rand_data(), rand_prio());
        else if (r < 85) send_item(OP_DELETE, d, rand_prio());
        else if (r < 95) send_item(OP_DISPLAY, rand_data(), rand_prio());
        else send_item(OP_NONE, rand_data(), rand_prio());
      end else begin
        if (r < 60) send_item(OP_DELETE, d, rand_prio());
        else if (r < 70) send_item(OP_DELETE, rand_data(), rand_prio());
        else if (r < 82) send_item(OP_INSERT, rand_data(), rand_prio());
        else if (r < 94) send_item(OP_DISPLAY, rand_data(), rand_prio());
        else send_item(OP_NONE, rand_data(), rand_prio());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = OP_NONE;
    data_value_i = '0;
    priority_value_i = '0;
    shadow_fill = 0;
    items_sent = 0;
    results_checked = 0;
    mismatches = 0;
    full_rejects = 0;
    displays = 0;
    burst_left = 0;
    hold_request = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_delete_cases();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
             results_checked, mismatches);
    $display("%0d displays, %0d inserts refused on a full queue", displays, full_rejects);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_ram.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue_unit.sv
bench/sorted_priority_queue_unit_test.sv
